/* rtl/samp_pkg.sv */
// Shared constants and types for the step/direction pulse generator.
`timescale 1ns / 1ps

package samp_pkg;

	// Fixed field widths
	localparam int ANGLE_W   = 24;
	localparam int SCALE_W   = 24;
	localparam int HALF_W    = 16;
	localparam int POS_OUT_W = 32;
	localparam int PROD_W    = ANGLE_W + SCALE_W;
	localparam int FRAC_W    = 24;

	// Parameter defaults
	localparam int DEF_POSITION_BITS = 32;
	localparam int DEF_PERIOD_BITS   = 16;

	// Scale register reset: Q8.16 steps per degree
	localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd36409;

	// Opcodes
	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Control travelling with a command through the front stages
	typedef struct packed {
		logic valid;
		logic op;
	} cmd_ctl_t;

endpackage

/* rtl/stepper_absolute_move_pulse_gen_core.sv */
// Top level of the step/direction pulse generator with absolute positioning.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries move commands (opcode 0, with
//   target_angle and half_period) and one-microsecond ticks (opcode 1).
//   Every input transaction yields exactly one result transaction on the
//   output channel (out_valid / out_stall): pulse level, direction, busy flag,
//   position after the transaction and a reject flag for moves that arrive
//   while busy.
//   From input accept to result valid, a transaction passes the input register,
//   scale multiply, rounding/saturation, then the motion state update that
//   loads the result register. Throughput is one transaction per cycle while
//   out_stall is low, set by the motion state update.
//   cfg_wr_en / cfg_wr_data write the Q8.16 steps-per-degree scale; write it
//   only while no transaction is in flight.
//   Reset clears position, target and pulse timer, sets the latched half
//   period to one and the scale to its default.
//   When the receiver stalls, the result register holds; the front stages
//   keep filling until every stage is occupied, then in_stall rises.

module stepper_absolute_move_pulse_gen_core import samp_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int PERIOD_BITS   = DEF_PERIOD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic signed [ANGLE_W-1:0]   target_angle,
	input  logic        [HALF_W-1:0]    half_period,
	input  logic                        cfg_wr_en,
	input  logic        [SCALE_W-1:0]   cfg_wr_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        pulse_level,
	output logic                        direction,
	output logic                        busy_res,
	output logic signed [POS_OUT_W-1:0] position,
	output logic                        rejected
);

	cmd_ctl_t                        ctl;
	logic signed [POSITION_BITS-1:0] steps;
	logic        [PERIOD_BITS-1:0]   hp;
	logic                            take;

	samp_cmd_pipe #(
		.POSITION_BITS (POSITION_BITS),
		.PERIOD_BITS   (PERIOD_BITS)
	) u_cmd_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.target_angle (target_angle),
		.half_period  (half_period),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.take         (take),
		.ctl          (ctl),
		.steps        (steps),
		.hp           (hp)
	);

	samp_motion #(
		.POSITION_BITS (POSITION_BITS),
		.PERIOD_BITS   (PERIOD_BITS)
	) u_motion (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.steps       (steps),
		.hp          (hp),
		.take        (take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pulse_level (pulse_level),
		.direction   (direction),
		.busy_res    (busy_res),
		.position    (position),
		.rejected    (rejected)
	);

endmodule

/* rtl/samp_cmd_pipe.sv */
// Front pipeline: input register, angle scaling multiply, rounding and saturation.
`timescale 1ns / 1ps

module samp_cmd_pipe import samp_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int PERIOD_BITS   = DEF_PERIOD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic signed [ANGLE_W-1:0]       target_angle,
	input  logic        [HALF_W-1:0]        half_period,
	input  logic                            cfg_wr_en,
	input  logic        [SCALE_W-1:0]       cfg_wr_data,
	input  logic                            take,
	output cmd_ctl_t                        ctl,
	output logic signed [POSITION_BITS-1:0] steps,
	output logic        [PERIOD_BITS-1:0]   hp
);

	localparam int CW  = ((POSITION_BITS > FRAC_W + 1) ? POSITION_BITS : FRAC_W + 1) + 1;
	localparam int CLW = (PERIOD_BITS > HALF_W) ? PERIOD_BITS : HALF_W;

	logic [SCALE_W-1:0] scale_q;

	logic                      v_s1, v_s2, v_s3;
	logic                      op_s1, op_s2, op_s3;
	logic [ANGLE_W-1:0]        angle_s1;
	logic [HALF_W-1:0]         half_s1;
	logic                      neg_s2;
	logic [PROD_W-1:0]         prod_s2;
	logic [PERIOD_BITS-1:0]    hp_s2, hp_s3;
	logic [POSITION_BITS-1:0]  steps_s3;

	logic en1, en2, en3;

	logic                   neg1;
	logic [ANGLE_W-1:0]     mag1;
	logic [HALF_W-1:0]      half_nz;
	logic [CLW-1:0]         half_ext;
	logic [CLW-1:0]         pmax_ext;
	logic [PERIOD_BITS-1:0] hp_clamp;

	logic [PROD_W:0]        rounded;
	logic [CW-1:0]          s_ext;
	logic [CW-1:0]          maxp_ext;
	logic [CW-1:0]          minmag_ext;
	logic [CW-1:0]          sat_ext;

	// Stage enables: a stage moves when it is empty or its successor moves
	assign en3      = !v_s3 || take;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	// Hold the scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	// Valid bits of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Stage 1: capture the transaction
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1    <= opcode;
			angle_s1 <= target_angle;
			half_s1  <= half_period;
		end
	end

	// Take the magnitude of the angle and clamp the half period
	always_comb begin
		neg1     = angle_s1[ANGLE_W-1];
		mag1     = neg1 ? (~angle_s1 + ANGLE_W'(1)) : angle_s1;
		half_nz  = (half_s1 == '0) ? HALF_W'(1) : half_s1;
		half_ext = CLW'(half_nz);
		pmax_ext = CLW'({PERIOD_BITS{1'b1}});
		hp_clamp = (half_ext > pmax_ext) ? PERIOD_BITS'(pmax_ext) : PERIOD_BITS'(half_ext);
	end

	// Stage 2: scale the magnitude
	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2   <= op_s1;
			neg_s2  <= neg1;
			prod_s2 <= PROD_W'(mag1) * PROD_W'(scale_q);
			hp_s2   <= hp_clamp;
		end
	end

	// Round half away from zero, then saturate to the position range
	always_comb begin
		rounded    = {1'b0, prod_s2} + ((PROD_W + 1)'(1) << (FRAC_W - 1));
		s_ext      = CW'(rounded[PROD_W:FRAC_W]);
		maxp_ext   = CW'({(POSITION_BITS-1){1'b1}});
		minmag_ext = CW'(1) << (POSITION_BITS - 1);
		if (neg_s2) begin
			sat_ext = (s_ext > minmag_ext) ? minmag_ext : s_ext;
			sat_ext = ~sat_ext + CW'(1);
		end else begin
			sat_ext = (s_ext > maxp_ext) ? maxp_ext : s_ext;
		end
	end

	// Stage 3: converted step target
	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3    <= op_s2;
			steps_s3 <= sat_ext[POSITION_BITS-1:0];
			hp_s3    <= hp_s2;
		end
	end

	assign ctl.valid = v_s3;
	assign ctl.op    = op_s3;
	assign steps     = steps_s3;
	assign hp        = hp_s3;

endmodule

/* rtl/samp_motion.sv */
// Motion state: pulse timer, position tracking, busy check and result register.
`timescale 1ns / 1ps

module samp_motion import samp_pkg::*; #(
	parameter int POSITION_BITS = DEF_POSITION_BITS,
	parameter int PERIOD_BITS   = DEF_PERIOD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmd_ctl_t                        ctl,
	input  logic signed [POSITION_BITS-1:0] steps,
	input  logic        [PERIOD_BITS-1:0]   hp,
	output logic                            take,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            pulse_level,
	output logic                            direction,
	output logic                            busy_res,
	output logic signed [POS_OUT_W-1:0]     position,
	output logic                            rejected
);

	logic signed [POSITION_BITS-1:0] cur_q, tgt_q;
	logic        [PERIOD_BITS-1:0]   hpl_q, pc_q;
	logic                            ph_q, up_q;

	logic                            out_v_q;
	logic                            level_q, dir_q, busy_q, rej_q;
	logic signed [POS_OUT_W-1:0]     pos_q;

	logic                            fire;
	logic                            busy_now;
	logic                            start;
	logic signed [POSITION_BITS-1:0] cur_n, tgt_n;
	logic        [PERIOD_BITS-1:0]   hpl_n, pc_n, pc1;
	logic                            ph_n, up_n, ph1, up1;
	logic                            level, rej, busy_n;

	assign take = !out_v_q || !out_stall;
	assign fire = ctl.valid && take;

	assign busy_now = (cur_q != tgt_q) || ph_q || (pc_q != '0);

	// Next state for one move or tick
	always_comb begin
		cur_n = cur_q;
		tgt_n = tgt_q;
		hpl_n = hpl_q;
		pc_n  = pc_q;
		ph_n  = ph_q;
		up_n  = up_q;
		level = ph_q;
		rej   = 1'b0;
		start = 1'b0;
		ph1   = ph_q;
		pc1   = pc_q;
		up1   = up_q;
		case (ctl.op)
			OP_MOVE: begin
				if (busy_now) begin
					rej = 1'b1;
				end else begin
					hpl_n = hp;
					tgt_n = steps;
					if (steps != cur_q) begin
						up_n = steps > cur_q;
					end
				end
			end
			OP_TICK: begin
				// start a pulse when idle away from target
				start = !ph_q && (pc_q == '0) && (cur_q != tgt_q);
				ph1   = ph_q || start;
				pc1   = start ? hpl_q : pc_q;
				up1   = start ? (tgt_q > cur_q) : up_q;
				up_n  = up1;
				level = ph1;
				if (ph1) begin
					pc_n = pc1 - PERIOD_BITS'(1);
					if (pc_n == '0) begin
						ph_n = 1'b0;
						pc_n = hpl_q;
					end else begin
						ph_n = 1'b1;
					end
				end else if (pc1 != '0) begin
					pc_n = pc1 - PERIOD_BITS'(1);
					if (pc_n == '0) begin
						cur_n = up1 ? (cur_q + POSITION_BITS'(1)) : (cur_q - POSITION_BITS'(1));
					end
				end
			end
			default: begin
				rej = 1'b0;
			end
		endcase
		busy_n = (cur_n != tgt_n) || ph_n || (pc_n != '0);
	end

	// Advance the motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			tgt_q <= '0;
			hpl_q <= PERIOD_BITS'(1);
			pc_q  <= '0;
			ph_q  <= 1'b0;
			up_q  <= 1'b0;
		end else if (fire) begin
			cur_q <= cur_n;
			tgt_q <= tgt_n;
			hpl_q <= hpl_n;
			pc_q  <= pc_n;
			ph_q  <= ph_n;
			up_q  <= up_n;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take) begin
			out_v_q <= ctl.valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			level_q <= level;
			dir_q   <= up_n;
			busy_q  <= busy_n;
			pos_q   <= POS_OUT_W'(cur_n);
			rej_q   <= rej;
		end
	end

	assign out_valid   = out_v_q;
	assign pulse_level = level_q;
	assign direction   = dir_q;
	assign busy_res    = busy_q;
	assign position    = pos_q;
	assign rejected    = rej_q;

	// Phase counter never runs past the latched half period
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= hpl_q) else $error("phase counter above half period");

	// A high phase always has ticks left
	a_high_count: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q |-> (pc_q != '0)) else $error("high phase with empty counter");

	// A dropped move was seen while busy
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && rej_q) |-> busy_q) else $error("rejected move while idle");

	// Position moves by at most one step per transaction
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cur_q) |-> ((cur_q == $past(cur_q) + POSITION_BITS'(1)) ||
		                     (cur_q == $past(cur_q) - POSITION_BITS'(1))))
		else $error("position jumped by more than one step");

endmodule
